// File: design/rti_pkg.sv
// Package: word types, widths and coordinate helpers for the ray/triangle unit.
package rti_pkg;

	localparam int CW   = 21;
	localparam int EW   = 22;
	localparam int XW   = 45;
	localparam int PLW  = 46;
	localparam int PHW  = 44;
	localparam int LOW  = 23;
	localparam int DW   = 70;
	localparam int FRAC = 16;
	localparam int TQW  = 32;
	localparam int UVW  = 17;
	localparam int NDIV = 32;
	localparam int PW   = 54;
	localparam int SW   = 39;
	localparam int EPS_SHIFT = 14;
	localparam int NS   = 41;
	localparam int SD   = 8;
	localparam logic signed [SW-1:0] CMAX = SW'(1048575);
	localparam logic signed [SW-1:0] CMIN = -SW'(1048576);

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		logic [62:0] ray_origin;
		logic [62:0] ray_direction;
		logic [62:0] vertex_a;
		logic [62:0] vertex_b;
		logic [62:0] vertex_c;
		logic [31:0] near_limit;
		logic [31:0] far_limit;
	} ray_word_t;

	typedef struct packed {
		logic        is_hit;
		logic [31:0] hit_distance;
		logic [16:0] weight_u;
		logic [16:0] weight_v;
		logic [62:0] hit_point;
	} hit_word_t;

	typedef struct packed {
		logic [62:0] org;
		logic [62:0] dir;
		logic [31:0] near_v;
		logic [31:0] far_v;
	} carry_t;

	typedef struct packed {
		logic [DW-1:0]   d;
		logic [DW-1:0]   rt;
		logic [DW-1:0]   ru;
		logic [DW-1:0]   rv;
		logic [FRAC-1:0] tlow;
		logic            ulow;
		logic            vlow;
		logic [TQW-1:0]  tq;
		logic [UVW-1:0]  uq;
		logic [UVW-1:0]  vq;
		logic            tsat;
		logic            rej;
		carry_t          c;
	} div_t;

	function automatic coord_t coord(input logic [62:0] w, input int i);
		coord = $signed(w[i*CW +: CW]);
	endfunction

endpackage

// File: design/ray_triangle_intersect.sv
// Ray/triangle intersection pipeline (Moller-Trumbore, fixed point).
// One test enters per cycle while ray_stall is low; most of the depth is the
// restoring divider, one quotient bit of t per stage over 32 stages, with u and v done in
// the first 17 of them. Each stage holds its word until the next one is free, so bubbles
// close up under stall.
module ray_triangle_intersect (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ray_valid,
	output logic                ray_stall,
	input  rti_pkg::ray_word_t  ray,
	output logic                hit_valid,
	input  logic                hit_stall,
	output rti_pkg::hit_word_t  hit
);

	logic [rti_pkg::NS:1]   vld_q;
	logic [rti_pkg::NS+1:1] rdy;

	assign rdy[rti_pkg::NS+1] = !hit_stall;
	for (genvar k = 1; k <= rti_pkg::NS; k++) begin : g_rdy
		assign rdy[k] = !vld_q[k] || rdy[k+1];
	end
	assign ray_stall = !rdy[1];
	assign hit_valid = vld_q[rti_pkg::NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= ray_valid;
			end
			for (int k = 2; k <= rti_pkg::NS; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	rti_pkg::carry_t c_s1, c_s2, c_s3, c_s4, c_s5, c_s6;
	logic signed [rti_pkg::EW-1:0]  e1_s1 [3], e2_s1 [3], s_s1 [3];
	logic signed [rti_pkg::EW-1:0]  e1_s2 [3], e2_s2 [3], s_s2 [3];
	logic signed [rti_pkg::XW-1:0]  p_s2 [3], q_s2 [3];
	logic signed [rti_pkg::PLW-1:0] pl_s3 [4][3];
	logic signed [rti_pkg::PHW-1:0] ph_s3 [4][3];
	logic signed [rti_pkg::DW-1:0]  term_s4 [4][3];
	logic signed [rti_pkg::DW-1:0]  dot_s5 [4];
	logic signed [rti_pkg::DW-1:0]  fix_s6 [4];
	rti_pkg::div_t dinit_s7;
	rti_pkg::div_t div_s8_39 [rti_pkg::NDIV];

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			c_s1 <= '{org: ray.ray_origin, dir: ray.ray_direction,
				near_v: ray.near_limit, far_v: ray.far_limit};
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= rti_pkg::EW'(rti_pkg::coord(ray.vertex_b, i))
					- rti_pkg::EW'(rti_pkg::coord(ray.vertex_a, i));
				e2_s1[i] <= rti_pkg::EW'(rti_pkg::coord(ray.vertex_c, i))
					- rti_pkg::EW'(rti_pkg::coord(ray.vertex_a, i));
				s_s1[i] <= rti_pkg::EW'(rti_pkg::coord(ray.ray_origin, i))
					- rti_pkg::EW'(rti_pkg::coord(ray.vertex_a, i));
			end
		end
	end

	logic signed [rti_pkg::EW-1:0] dir1 [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dir1[i] = rti_pkg::EW'(rti_pkg::coord(c_s1.dir, i));
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			c_s2 <= c_s1;
			e1_s2 <= e1_s1;
			e2_s2 <= e2_s1;
			s_s2 <= s_s1;
			for (int i = 0; i < 3; i++) begin
				p_s2[i] <= rti_pkg::XW'(dir1[(i+1)%3] * e2_s1[(i+2)%3])
					- rti_pkg::XW'(dir1[(i+2)%3] * e2_s1[(i+1)%3]);
				q_s2[i] <= rti_pkg::XW'(s_s1[(i+1)%3] * e1_s1[(i+2)%3])
					- rti_pkg::XW'(s_s1[(i+2)%3] * e1_s1[(i+1)%3]);
			end
		end
	end

	logic signed [rti_pkg::EW-1:0] aop [4][3];
	logic signed [rti_pkg::XW-1:0] bop [4][3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			aop[0][i] = e1_s2[i];
			bop[0][i] = p_s2[i];
			aop[1][i] = s_s2[i];
			bop[1][i] = p_s2[i];
			aop[2][i] = rti_pkg::EW'(rti_pkg::coord(c_s2.dir, i));
			bop[2][i] = q_s2[i];
			aop[3][i] = e2_s2[i];
			bop[3][i] = q_s2[i];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			c_s3 <= c_s2;
			for (int k = 0; k < 4; k++) begin
				for (int i = 0; i < 3; i++) begin
					pl_s3[k][i] <= rti_pkg::PLW'(aop[k][i]
						* $signed({1'b0, bop[k][i][rti_pkg::LOW-1:0]}));
					ph_s3[k][i] <= rti_pkg::PHW'(aop[k][i]
						* $signed(bop[k][i][rti_pkg::XW-1:rti_pkg::LOW]));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			c_s4 <= c_s3;
			for (int k = 0; k < 4; k++) begin
				for (int i = 0; i < 3; i++) begin
					term_s4[k][i] <= (rti_pkg::DW'(ph_s3[k][i]) <<< rti_pkg::LOW)
						+ rti_pkg::DW'(pl_s3[k][i]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			c_s5 <= c_s4;
			for (int k = 0; k < 4; k++) begin
				dot_s5[k] <= term_s4[k][0] + term_s4[k][1] + term_s4[k][2];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			c_s6 <= c_s5;
			for (int k = 0; k < 4; k++) begin
				fix_s6[k] <= dot_s5[0][rti_pkg::DW-1] ? -dot_s5[k] : dot_s5[k];
			end
		end
	end

	logic signed [rti_pkg::DW-1:0] eps6;
	logic signed [rti_pkg::DW:0]   uv6;
	rti_pkg::div_t                 dinit;
	assign eps6 = $signed(rti_pkg::DW'(c_s6.near_v) << rti_pkg::EPS_SHIFT);
	assign uv6  = (rti_pkg::DW+1)'(fix_s6[1]) + (rti_pkg::DW+1)'(fix_s6[2]);

	always_comb begin
		dinit      = '0;
		dinit.c    = c_s6;
		dinit.d    = fix_s6[0];
		dinit.rt   = fix_s6[3] >>> rti_pkg::FRAC;
		dinit.tlow = fix_s6[3][rti_pkg::FRAC-1:0];
		dinit.ru   = fix_s6[1] >>> 1;
		dinit.ulow = fix_s6[1][0];
		dinit.rv   = fix_s6[2] >>> 1;
		dinit.vlow = fix_s6[2][0];
		dinit.tsat = (fix_s6[3] >>> rti_pkg::FRAC) >= fix_s6[0];
		dinit.rej  = (fix_s6[0] == '0) || (fix_s6[0] < eps6)
			|| fix_s6[1][rti_pkg::DW-1] || (fix_s6[1] > fix_s6[0])
			|| fix_s6[2][rti_pkg::DW-1] || (uv6 > (rti_pkg::DW+1)'(fix_s6[0]))
			|| fix_s6[3][rti_pkg::DW-1];
	end

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			dinit_s7 <= dinit;
		end
	end

	for (genvar j = 0; j < rti_pkg::NDIV; j++) begin : g_div
		rti_pkg::div_t prv, nxt;
		logic [rti_pkg::DW:0] t2, u2, v2;
		if (j == 0) begin : g_first
			assign prv = dinit_s7;
		end else begin : g_next
			assign prv = div_s8_39[j-1];
		end
		always_comb begin
			nxt = prv;
			t2  = {prv.rt, (j < rti_pkg::FRAC) ? prv.tlow[rti_pkg::FRAC-1-(j%rti_pkg::FRAC)]
				: 1'b0};
			u2  = {prv.ru, (j == 0) ? prv.ulow : 1'b0};
			v2  = {prv.rv, (j == 0) ? prv.vlow : 1'b0};
			if (t2 >= {1'b0, prv.d}) begin
				nxt.rt = rti_pkg::DW'(t2 - {1'b0, prv.d});
				nxt.tq = {prv.tq[rti_pkg::TQW-2:0], 1'b1};
			end else begin
				nxt.rt = rti_pkg::DW'(t2);
				nxt.tq = {prv.tq[rti_pkg::TQW-2:0], 1'b0};
			end
			if (j < rti_pkg::UVW) begin
				if (u2 >= {1'b0, prv.d}) begin
					nxt.ru = rti_pkg::DW'(u2 - {1'b0, prv.d});
					nxt.uq = {prv.uq[rti_pkg::UVW-2:0], 1'b1};
				end else begin
					nxt.ru = rti_pkg::DW'(u2);
					nxt.uq = {prv.uq[rti_pkg::UVW-2:0], 1'b0};
				end
				if (v2 >= {1'b0, prv.d}) begin
					nxt.rv = rti_pkg::DW'(v2 - {1'b0, prv.d});
					nxt.vq = {prv.vq[rti_pkg::UVW-2:0], 1'b1};
				end else begin
					nxt.rv = rti_pkg::DW'(v2);
					nxt.vq = {prv.vq[rti_pkg::UVW-2:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk) begin
			if (rdy[rti_pkg::SD+j]) begin
				div_s8_39[j] <= nxt;
			end
		end
	end

	rti_pkg::div_t                  dl;
	logic [rti_pkg::TQW-1:0]        tq40;
	logic                           hit_s40;
	logic [rti_pkg::TQW-1:0]        tq_s40;
	logic [rti_pkg::UVW-1:0]        uq_s40, vq_s40;
	logic [62:0]                    org_s40;
	logic [31:0]                    far_s40;
	logic signed [rti_pkg::PW-1:0]  prod_s40 [3];

	assign dl   = div_s8_39[rti_pkg::NDIV-1];
	assign tq40 = dl.tsat ? '1 : dl.tq;

	always_ff @(posedge clk) begin
		if (rdy[rti_pkg::NS-1]) begin
			hit_s40 <= !dl.rej && (tq40 > dl.c.near_v) && (tq40 < dl.c.far_v);
			tq_s40  <= tq40;
			uq_s40  <= dl.uq;
			vq_s40  <= dl.vq;
			org_s40 <= dl.c.org;
			far_s40 <= dl.c.far_v;
			for (int i = 0; i < 3; i++) begin
				prod_s40[i] <= rti_pkg::PW'($signed({1'b0, tq40})
					* rti_pkg::coord(dl.c.dir, i));
			end
		end
	end

	logic signed [rti_pkg::SW-1:0] sum40 [3];
	logic [62:0]                   pt40;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum40[i] = rti_pkg::SW'(prod_s40[i] >>> rti_pkg::FRAC)
				+ rti_pkg::SW'(rti_pkg::coord(org_s40, i));
			if (sum40[i] > rti_pkg::CMAX) begin
				pt40[i*rti_pkg::CW +: rti_pkg::CW] = rti_pkg::CW'(rti_pkg::CMAX);
			end else if (sum40[i] < rti_pkg::CMIN) begin
				pt40[i*rti_pkg::CW +: rti_pkg::CW] = rti_pkg::CW'(rti_pkg::CMIN);
			end else begin
				pt40[i*rti_pkg::CW +: rti_pkg::CW] = rti_pkg::CW'(sum40[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[rti_pkg::NS]) begin
			hit.is_hit       <= hit_s40;
			hit.hit_distance <= hit_s40 ? tq_s40 : far_s40;
			hit.weight_u     <= hit_s40 ? uq_s40 : '0;
			hit.weight_v     <= hit_s40 ? vq_s40 : '0;
			hit.hit_point    <= hit_s40 ? pt40 : '0;
		end
	end

	a_uv_sum: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && hit.is_hit |->
		(18'(hit.weight_u) + 18'(hit.weight_v)) <= 18'd65536)
		else $error("weights exceed one");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && !hit.is_hit |->
		hit.weight_u == '0 && hit.weight_v == '0 && hit.hit_point == '0)
		else $error("miss word not cleared");
	a_hit_t: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && hit.is_hit |-> hit.hit_distance != '0 && hit.hit_distance != '1)
		else $error("hit distance out of interval");
	a_no_overtake: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && hit_stall |=> hit_valid && $stable(hit))
		else $error("output word dropped under stall");

endmodule
